[sv/bsfn_pkg.sv]
// Shared types and constants for the bitmap with set-bit count and find-next iterator.
package bsfn_pkg;

  // Default storage size in 64-bit words
  localparam int MAP_WORDS_DEFAULT = 16;

  // Capacity register reset value
  localparam logic [10:0] CAPACITY_RESET = 11'd1024;

  // Width of the effective capacity (holds up to 64 words of 64 bits)
  localparam int EFF_W = 13;

  // Queue between front and back
  localparam int QUEUE_DEPTH = 2;
  localparam int QPTR_W = 1;
  localparam int QCNT_W = 2;

  // Operation codes on the input beat
  localparam logic [2:0] OP_SET       = 3'd0;
  localparam logic [2:0] OP_CLEAR     = 3'd1;
  localparam logic [2:0] OP_TEST      = 3'd2;
  localparam logic [2:0] OP_FIND      = 3'd3;
  localparam logic [2:0] OP_RESTART   = 3'd4;
  localparam logic [2:0] OP_CLEAR_ALL = 3'd5;

  // Classified work kinds as queued for the back end
  typedef enum logic [2:0] {
    K_SET,
    K_CLEAR,
    K_TEST,
    K_ERROR,
    K_FIND,
    K_RESTART,
    K_CLEAR_ALL,
    K_NONE
  } kind_t;

  typedef struct packed {
    logic [2:0] operation;
    logic [9:0] bit_index;
  } item_t;

  typedef struct packed {
    logic        bit_is_set;
    logic        found;
    logic [9:0]  found_position;
    logic [10:0] set_count;
    logic        index_error;
  } result_t;

  typedef struct packed {
    kind_t      kind;
    logic [9:0] bit_index;
  } entry_t;

endpackage

[sv/bsfn_front.sv]
// Front end: accept input beats, range-check the index and classify the operation.
module bsfn_front (
  input  logic                       item_valid,
  output logic                       item_stall,
  input  bsfn_pkg::item_t            item,
  input  logic [bsfn_pkg::EFF_W-1:0] eff_capacity,
  input  logic                       queue_full,
  output logic                       push,
  output bsfn_pkg::entry_t           push_entry
);

  logic [bsfn_pkg::EFF_W-1:0] index_ext;
  logic                       out_of_range;

  // Hold the beat while the queue has no room
  assign item_stall = queue_full;
  assign push       = item_valid && !queue_full;

  assign index_ext    = {{(bsfn_pkg::EFF_W-10){1'b0}}, item.bit_index};
  assign out_of_range = index_ext >= eff_capacity;

  // Classify the operation
  always_comb begin
    push_entry.bit_index = item.bit_index;
    unique case (item.operation)
      bsfn_pkg::OP_SET:       push_entry.kind = out_of_range ? bsfn_pkg::K_ERROR : bsfn_pkg::K_SET;
      bsfn_pkg::OP_CLEAR:     push_entry.kind = out_of_range ? bsfn_pkg::K_ERROR : bsfn_pkg::K_CLEAR;
      bsfn_pkg::OP_TEST:      push_entry.kind = out_of_range ? bsfn_pkg::K_ERROR : bsfn_pkg::K_TEST;
      bsfn_pkg::OP_FIND:      push_entry.kind = bsfn_pkg::K_FIND;
      bsfn_pkg::OP_RESTART:   push_entry.kind = bsfn_pkg::K_RESTART;
      bsfn_pkg::OP_CLEAR_ALL: push_entry.kind = bsfn_pkg::K_CLEAR_ALL;
      default:                push_entry.kind = bsfn_pkg::K_NONE;
    endcase
  end

endmodule

[sv/bsfn_queue.sv]
// Short queue of classified work between the front and back ends.
module bsfn_queue (
  input  logic             clk,
  input  logic             rst,
  input  logic             push,
  input  bsfn_pkg::entry_t push_entry,
  output logic             full,
  input  logic             pop,
  output logic             empty,
  output bsfn_pkg::entry_t head
);

  bsfn_pkg::entry_t                entries [bsfn_pkg::QUEUE_DEPTH];
  logic [bsfn_pkg::QPTR_W-1:0]     wr_ptr;
  logic [bsfn_pkg::QPTR_W-1:0]     rd_ptr;
  logic [bsfn_pkg::QCNT_W-1:0]     fill;

  assign full  = fill == bsfn_pkg::QCNT_W'(bsfn_pkg::QUEUE_DEPTH);
  assign empty = fill == '0;
  assign head  = entries[rd_ptr];

  // Store pushed entries
  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= push_entry;
    end
  end

  // Advance pointers and fill count
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      fill   <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        fill <= fill + 1'b1;
      end else if (pop && !push) begin
        fill <= fill - 1'b1;
      end
    end
  end

endmodule

[sv/bsfn_back.sv]
// Back end: bitmap word store, bit updates, count, find-next word walk and result register.
module bsfn_back #(
  parameter int MAP_WORDS = bsfn_pkg::MAP_WORDS_DEFAULT
) (
  input  logic                               clk,
  input  logic                               rst,
  input  logic [((MAP_WORDS > 1) ? $clog2(MAP_WORDS) : 1):0] word_total,
  input  logic                               q_empty,
  input  bsfn_pkg::entry_t                   q_head,
  output logic                               q_pop,
  output logic                               result_valid,
  input  logic                               result_stall,
  output bsfn_pkg::result_t                  result
);

  localparam int WIDX_W = (MAP_WORDS > 1) ? $clog2(MAP_WORDS) : 1;
  localparam int POS_W  = WIDX_W + 6;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_ACCESS,
    ST_SCAN,
    ST_ENCODE
  } state_t;

  state_t                 state;
  bsfn_pkg::entry_t       work;
  logic [WIDX_W-1:0]      cur_w;
  logic                   first_masked;
  logic                   last_valid;
  logic [POS_W-1:0]       hit_pos;
  logic [10:0]            ones_count;
  logic [63:0]            lowest_bit;
  logic [MAP_WORDS-1:0]   word_valid;

  // Word store
  logic [63:0]            mem [MAP_WORDS];
  logic [63:0]            rd_data;
  logic                   rd_valid;
  logic                   rd_en;
  logic [WIDX_W-1:0]      rd_addr;
  logic                   wr_en;
  logic [63:0]            wr_data;

  logic                   out_free;
  logic [WIDX_W+3:0]      q_addr_wide;
  logic [WIDX_W-1:0]      q_addr;
  logic [WIDX_W+3:0]      work_addr_wide;
  logic [WIDX_W-1:0]      work_addr;
  logic [WIDX_W-1:0]      start_w;
  logic                   start_ok;
  logic [WIDX_W:0]        next_w;
  logic                   more_words;
  logic [63:0]            word;
  logic [63:0]            bit_mask;
  logic                   cur_bit;
  logic [6:0]             keep_shift;
  logic [63:0]            keep_mask;
  logic [63:0]            scan_word;
  logic [63:0]            scan_lowest;
  logic [5:0]             bit_enc;
  logic [POS_W-1:0]       found_pos;
  logic [POS_W+9:0]       found_pos_wide;
  logic                   res_load;
  bsfn_pkg::result_t      res_val;
  logic [10:0]            count_next;

  assign out_free = !result_valid || !result_stall;

  // Word addresses from bit indexes
  assign q_addr_wide    = {{WIDX_W{1'b0}}, q_head.bit_index[9:6]};
  assign q_addr         = q_addr_wide[WIDX_W-1:0];
  assign work_addr_wide = {{WIDX_W{1'b0}}, work.bit_index[9:6]};
  assign work_addr      = work_addr_wide[WIDX_W-1:0];

  // Find start word and walk limit
  assign start_w    = last_valid ? hit_pos[POS_W-1:6] : '0;
  assign start_ok   = {1'b0, start_w} < word_total;
  assign next_w     = {1'b0, cur_w} + 1'b1;
  assign more_words = next_w < word_total;

  // Word read back; words never written since reset or clear all read as zero
  assign word     = rd_valid ? rd_data : 64'd0;
  assign bit_mask = 64'd1 << work.bit_index[5:0];
  assign cur_bit  = word[work.bit_index[5:0]];

  // Drop bits at and below the last found position in the first word walked
  assign keep_shift  = {1'b0, hit_pos[5:0]} + 7'd1;
  assign keep_mask   = ~64'd0 << keep_shift;
  assign scan_word   = first_masked ? (word & keep_mask) : word;
  assign scan_lowest = scan_word & (~scan_word + 64'd1);

  // Encode the isolated lowest bit
  always_comb begin
    bit_enc = '0;
    for (int i = 0; i < 64; i++) begin
      if (lowest_bit[i]) begin
        bit_enc = bit_enc | 6'(i);
      end
    end
  end

  assign found_pos      = {cur_w, bit_enc};
  assign found_pos_wide = {10'd0, found_pos};

  // Sequence memory accesses and form results
  always_comb begin
    q_pop      = 1'b0;
    rd_en      = 1'b0;
    rd_addr    = q_addr;
    wr_en      = 1'b0;
    wr_data    = word;
    res_load   = 1'b0;
    res_val    = '0;
    count_next = ones_count;
    unique case (state)
      ST_IDLE: begin
        if (!q_empty && out_free) begin
          q_pop = 1'b1;
          unique case (q_head.kind)
            bsfn_pkg::K_SET, bsfn_pkg::K_CLEAR, bsfn_pkg::K_TEST: begin
              rd_en   = 1'b1;
              rd_addr = q_addr;
            end
            bsfn_pkg::K_FIND: begin
              if (start_ok) begin
                rd_en   = 1'b1;
                rd_addr = start_w;
              end else begin
                res_load = 1'b1;
              end
            end
            bsfn_pkg::K_ERROR: begin
              res_load            = 1'b1;
              res_val.index_error = 1'b1;
            end
            bsfn_pkg::K_CLEAR_ALL: begin
              res_load   = 1'b1;
              count_next = '0;
            end
            default: begin
              res_load = 1'b1;
            end
          endcase
        end
      end
      ST_ACCESS: begin
        res_load           = 1'b1;
        res_val.bit_is_set = cur_bit;
        if (work.kind == bsfn_pkg::K_SET && !cur_bit) begin
          wr_en      = 1'b1;
          wr_data    = word | bit_mask;
          count_next = ones_count + 11'd1;
        end else if (work.kind == bsfn_pkg::K_CLEAR && cur_bit) begin
          wr_en      = 1'b1;
          wr_data    = word & ~bit_mask;
          count_next = ones_count - 11'd1;
        end
      end
      ST_SCAN: begin
        if (scan_lowest == 64'd0) begin
          if (more_words) begin
            rd_en   = 1'b1;
            rd_addr = next_w[WIDX_W-1:0];
          end else begin
            res_load = 1'b1;
          end
        end
      end
      ST_ENCODE: begin
        res_load               = 1'b1;
        res_val.found          = 1'b1;
        res_val.found_position = found_pos_wide[9:0];
      end
      default: begin
        res_load = 1'b0;
      end
    endcase
    res_val.set_count = count_next;
  end

  // Word store: one write and one registered read per cycle
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[work_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data  <= mem[rd_addr];
      rd_valid <= word_valid[rd_addr];
    end
  end

  // State, iterator, count and result register
  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= ST_IDLE;
      last_valid   <= 1'b0;
      hit_pos      <= '0;
      ones_count   <= '0;
      word_valid   <= '0;
      result_valid <= 1'b0;
    end else begin
      ones_count <= count_next;
      // Load a new result beat, or drop the one taken
      if (res_load) begin
        result_valid <= 1'b1;
        result       <= res_val;
      end else if (result_valid && !result_stall) begin
        result_valid <= 1'b0;
      end
      if (wr_en) begin
        word_valid[work_addr] <= 1'b1;
      end
      unique case (state)
        ST_IDLE: begin
          if (q_pop) begin
            work <= q_head;
            unique case (q_head.kind)
              bsfn_pkg::K_SET, bsfn_pkg::K_CLEAR, bsfn_pkg::K_TEST: begin
                state <= ST_ACCESS;
              end
              bsfn_pkg::K_FIND: begin
                if (start_ok) begin
                  cur_w        <= start_w;
                  first_masked <= last_valid;
                  state        <= ST_SCAN;
                end else begin
                  last_valid <= 1'b0;
                  hit_pos    <= '0;
                end
              end
              bsfn_pkg::K_RESTART: begin
                last_valid <= 1'b0;
                hit_pos    <= '0;
              end
              bsfn_pkg::K_CLEAR_ALL: begin
                word_valid <= '0;
                last_valid <= 1'b0;
                hit_pos    <= '0;
              end
              default: begin
                state <= ST_IDLE;
              end
            endcase
          end
        end
        ST_ACCESS: begin
          state <= ST_IDLE;
        end
        ST_SCAN: begin
          if (scan_lowest != 64'd0) begin
            lowest_bit <= scan_lowest;
            state      <= ST_ENCODE;
          end else if (more_words) begin
            cur_w        <= next_w[WIDX_W-1:0];
            first_masked <= 1'b0;
          end else begin
            last_valid <= 1'b0;
            hit_pos    <= '0;
            state      <= ST_IDLE;
          end
        end
        ST_ENCODE: begin
          last_valid <= 1'b1;
          hit_pos    <= found_pos;
          state      <= ST_IDLE;
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

endmodule

[sv/bitmap_set_with_find_next.sv]
// The back end takes one item at a time and pops the next only in its idle state with the
// result register free. Set, clear and test read their word, then update it if needed and
// load the result in the access state; other simple ops load their result on the pop; a find
// reads the words from the last hit one by one in the scan state, then the encode state, as
// the word store has a single read port. Synchronous reset empties the map at once through
// per-word valid bits, clears count and iterator, and sets capacity_bits to 1024.
module bitmap_set_with_find_next #(
  parameter int MAP_WORDS = bsfn_pkg::MAP_WORDS_DEFAULT
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              item_valid,
  output logic              item_stall,
  input  bsfn_pkg::item_t   item,
  output logic              result_valid,
  input  logic              result_stall,
  output bsfn_pkg::result_t result,
  input  logic              cfg_write_en,
  input  logic [10:0]       cfg_write_data
);

  localparam int WIDX_W = (MAP_WORDS > 1) ? $clog2(MAP_WORDS) : 1;
  localparam logic [bsfn_pkg::EFF_W-1:0] CAP_LIMIT = bsfn_pkg::EFF_W'(MAP_WORDS * 64);

  logic [10:0]                capacity_bits;
  logic [bsfn_pkg::EFF_W-1:0] cap_ext;
  logic [bsfn_pkg::EFF_W-1:0] eff_capacity;
  logic [bsfn_pkg::EFF_W-1:0] words_wide;
  logic [WIDX_W:0]            word_total;

  logic                       push;
  bsfn_pkg::entry_t           push_entry;
  logic                       queue_full;
  logic                       q_pop;
  logic                       q_empty;
  bsfn_pkg::entry_t           q_head;

  // Hold the capacity register
  always_ff @(posedge clk) begin
    if (rst) begin
      capacity_bits <= bsfn_pkg::CAPACITY_RESET;
    end else if (cfg_write_en) begin
      capacity_bits <= cfg_write_data;
    end
  end

  // Saturate capacity to storage and count the words a find walks
  assign cap_ext      = {{(bsfn_pkg::EFF_W-11){1'b0}}, capacity_bits};
  assign eff_capacity = (cap_ext < CAP_LIMIT) ? cap_ext : CAP_LIMIT;
  assign words_wide   = (eff_capacity + bsfn_pkg::EFF_W'(63)) >> 6;
  assign word_total   = words_wide[WIDX_W:0];

  bsfn_front u_front (
    .item_valid   (item_valid),
    .item_stall   (item_stall),
    .item         (item),
    .eff_capacity (eff_capacity),
    .queue_full   (queue_full),
    .push         (push),
    .push_entry   (push_entry)
  );

  bsfn_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .push_entry (push_entry),
    .full       (queue_full),
    .pop        (q_pop),
    .empty      (q_empty),
    .head       (q_head)
  );

  bsfn_back #(
    .MAP_WORDS (MAP_WORDS)
  ) u_back (
    .clk          (clk),
    .rst          (rst),
    .word_total   (word_total),
    .q_empty      (q_empty),
    .q_head       (q_head),
    .q_pop        (q_pop),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .result       (result)
  );

endmodule

[tb/sv/tb_top.sv]
// Self-checking testbench for the bitmap with set-bit count and find-next iterator.
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  // Operation codes the block does not define; it must leave its state alone
  localparam logic [2:0] OP_SPARE_LO = 3'd6;
  localparam logic [2:0] OP_SPARE_HI = 3'd7;
  localparam int MAP_BITS = bsfn_pkg::MAP_WORDS_DEFAULT * 64;
  localparam int RANDOM_PER_PHASE = 150;
  localparam int HOLD_AFTER = 300;
  localparam int HOLD_CYCLES = 250;

  // Tracks the bitmap contents and holds the results it still owes
  class bitmap_checker;
    logic [63:0]       words [bsfn_pkg::MAP_WORDS_DEFAULT];
    logic [10:0]       ones;
    bit                last_valid;
    logic [9:0]        hit_pos;
    logic [10:0]       capacity;
    bsfn_pkg::result_t expected_results [$];
    int                mismatches;
    int                checked;

    function new();
      empty_map();
      capacity = bsfn_pkg::CAPACITY_RESET;
      mismatches = 0;
      checked = 0;
    endfunction

    function void empty_map();
      foreach (words[i]) words[i] = '0;
      ones = '0;
      last_valid = 1'b0;
      hit_pos = '0;
    endfunction

    function int unsigned eff_capacity();
      return (capacity < MAP_BITS) ? capacity : MAP_BITS;
    endfunction

    // Walk whole words from the last hit; forget the position when nothing is left
    function bit find_next_set(output logic [9:0] pos);
      int unsigned nwords;
      int unsigned first;
      int unsigned w;
      int unsigned b;
      logic [63:0] word;
      pos = '0;
      nwords = (eff_capacity() + 63) >> 6;
      first = last_valid ? (hit_pos >> 6) : 0;
      for (w = first; w < nwords; w++) begin
        word = words[w];
        // drop the last hit and every bit below it
        if (last_valid && w == first)
          word = word & ~((64'd2 << hit_pos[5:0]) - 64'd1);
        if (word != '0) begin
          b = 0;
          while (!word[b]) b++;
          pos = 10'(w * 64 + b);
          last_valid = 1'b1;
          hit_pos = pos;
          return 1'b1;
        end
      end
      last_valid = 1'b0;
      hit_pos = '0;
      return 1'b0;
    endfunction

    // Apply one accepted beat to the shadow map and queue the result it owes
    function void note_item(bsfn_pkg::item_t it);
      bsfn_pkg::result_t r;
      int unsigned       w;
      logic [9:0]        fpos;
      r = '0;
      case (it.operation)
        bsfn_pkg::OP_SET, bsfn_pkg::OP_CLEAR, bsfn_pkg::OP_TEST: begin
          if (it.bit_index >= eff_capacity()) begin
            r.index_error = 1'b1;
          end else begin
            w = it.bit_index >> 6;
            r.bit_is_set = words[w][it.bit_index[5:0]];
            if (it.operation == bsfn_pkg::OP_SET && !r.bit_is_set) begin
              words[w][it.bit_index[5:0]] = 1'b1;
              ones = ones + 11'd1;
            end else if (it.operation == bsfn_pkg::OP_CLEAR && r.bit_is_set) begin
              words[w][it.bit_index[5:0]] = 1'b0;
              ones = ones - 11'd1;
            end
          end
        end
        bsfn_pkg::OP_FIND: begin
          if (find_next_set(fpos)) begin
            r.found = 1'b1;
            r.found_position = fpos;
          end
        end
        bsfn_pkg::OP_RESTART: begin
          last_valid = 1'b0;
          hit_pos = '0;
        end
        bsfn_pkg::OP_CLEAR_ALL: empty_map();
        default: ;
      endcase
      r.set_count = ones;
      expected_results.push_back(r);
    endfunction

    function void report(string what, bsfn_pkg::result_t want, bsfn_pkg::result_t got);
      mismatches++;
      if (mismatches <= 10) begin
        $write("%0t: %s: exp set=%0d found=%0d pos=%0d count=%0d err=%0d, ",
               $time, what, want.bit_is_set, want.found, want.found_position,
               want.set_count, want.index_error);
        $display("got set=%0d found=%0d pos=%0d count=%0d err=%0d",
                 got.bit_is_set, got.found, got.found_position, got.set_count,
                 got.index_error);
      end
    endfunction

    // Compare an accepted result with the oldest one owed, field by field
    function void check_result(bsfn_pkg::result_t got);
      bsfn_pkg::result_t want;
      checked++;
      if (expected_results.size() == 0) begin
        report("unexpected result", '0, got);
        return;
      end
      want = expected_results.pop_front();
      if (got.bit_is_set !== want.bit_is_set || got.found !== want.found ||
          got.found_position !== want.found_position ||
          got.set_count !== want.set_count || got.index_error !== want.index_error)
        report("result mismatch", want, got);
    endfunction
  endclass

  logic              clk;
  logic              rst;
  logic              item_valid;
  logic              item_stall;
  bsfn_pkg::item_t   item_beat;
  logic              result_valid;
  logic              result_stall;
  bsfn_pkg::result_t result_beat;
  logic              cfg_write_en;
  logic [10:0]       cfg_write_data;

  bitmap_checker sb = new();
  bit            sender_calm;
  logic [10:0]   phase_caps [0:7];

  bitmap_set_with_find_next uut (
    .clk(clk),
    .rst(rst),
    .item_valid(item_valid),
    .item_stall(item_stall),
    .item(item_beat),
    .result_valid(result_valid),
    .result_stall(result_stall),
    .result(result_beat),
    .cfg_write_en(cfg_write_en),
    .cfg_write_data(cfg_write_data)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Mostly short gaps, now and then a long one
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 88) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(25, 70);
  endfunction

  // Record every beat that crosses either channel
  always @(posedge clk) begin
    if (!rst && item_valid && !item_stall) sb.note_item(item_beat);
    if (!rst && result_valid && !result_stall) sb.check_result(result_beat);
  end

  // Offer one beat after a random gap and hold it until taken
  task automatic send_item(logic [2:0] op, logic [9:0] idx);
    int              gap;
    bsfn_pkg::item_t it;
    gap = sender_calm ? 0 : pick_gap();
    if (gap > 0) begin
      item_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    it.operation = op;
    it.bit_index = idx;
    item_beat <= it;
    item_valid <= 1'b1;
    do @(posedge clk); while (item_stall);
    @(negedge clk);
  endtask

  // Let every owed result arrive, then write the capacity while the block is idle
  task automatic drain();
    item_valid <= 1'b0;
    while (sb.expected_results.size() != 0) @(negedge clk);
  endtask

  task automatic write_capacity(logic [10:0] cap);
    drain();
    cfg_write_en <= 1'b1;
    cfg_write_data <= cap;
    @(negedge clk);
    cfg_write_en <= 1'b0;
    sb.capacity = cap;
  endtask

  // Result side: random stalls, quiet stretches and one long hold-off
  initial begin : result_sink
    int  stall;
    bit  held;
    result_stall = 1'b0;
    held = 1'b0;
    @(negedge clk);
    forever begin
      if (!held && sb.checked >= HOLD_AFTER) begin
        held = 1'b1;
        result_stall <= 1'b1;
        repeat (HOLD_CYCLES) @(negedge clk);
      end else if ($urandom_range(0, 19) == 0) begin
        result_stall <= 1'b0;
        repeat ($urandom_range(20, 80)) @(negedge clk);
      end else begin
        stall = pick_gap();
        if (stall > 0) begin
          result_stall <= 1'b1;
          repeat (stall) @(negedge clk);
        end
        result_stall <= 1'b0;
        @(negedge clk);
      end
    end
  end

  initial begin : stimulus
    int          r;
    int unsigned eff;
    logic [2:0]  op;
    logic [9:0]  idx;
    rst = 1'b1;
    item_valid = 1'b0;
    item_beat = '0;
    cfg_write_en = 1'b0;
    cfg_write_data = '0;
    sender_calm = 1'b0;
    phase_caps = '{11'd2047, 11'd1, 11'd1000, 11'd128, 11'd1024, 11'd0, 11'd65, 11'd513};
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // Directed: full capacity, both ends of the index, every operation
    write_capacity(11'd1024);
    send_item(bsfn_pkg::OP_CLEAR_ALL, 10'd0);
    send_item(bsfn_pkg::OP_SET, 10'd0);
    send_item(bsfn_pkg::OP_SET, 10'd1023);
    send_item(bsfn_pkg::OP_SET, 10'd0);
    send_item(bsfn_pkg::OP_TEST, 10'd0);
    send_item(bsfn_pkg::OP_FIND, 10'd0);
    send_item(bsfn_pkg::OP_FIND, 10'd0);
    send_item(bsfn_pkg::OP_FIND, 10'd0);
    send_item(bsfn_pkg::OP_FIND, 10'd0);
    send_item(bsfn_pkg::OP_RESTART, 10'd0);
    send_item(bsfn_pkg::OP_FIND, 10'd0);
    send_item(bsfn_pkg::OP_SET, 10'd63);
    send_item(bsfn_pkg::OP_SET, 10'd64);
    send_item(bsfn_pkg::OP_SET, 10'd100);
    send_item(bsfn_pkg::OP_FIND, 10'd0);
    send_item(bsfn_pkg::OP_FIND, 10'd0);
    send_item(bsfn_pkg::OP_CLEAR, 10'd1023);
    send_item(bsfn_pkg::OP_CLEAR, 10'd1023);
    send_item(OP_SPARE_LO, 10'd1023);
    send_item(OP_SPARE_HI, 10'd0);
    send_item(bsfn_pkg::OP_SET, 10'd1023);
    send_item(bsfn_pkg::OP_FIND, 10'd0);
    // Last hit now lies beyond the words a one-word capacity scans
    write_capacity(11'd64);
    send_item(bsfn_pkg::OP_FIND, 10'd0);
    send_item(bsfn_pkg::OP_SET, 10'd100);
    // Bits above a lowered capacity still turn up in the last scanned word
    write_capacity(11'd65);
    repeat (4) send_item(bsfn_pkg::OP_FIND, 10'd0);
    send_item(bsfn_pkg::OP_TEST, 10'd100);
    // Zero capacity: every index is out of range and finds see nothing
    write_capacity(11'd0);
    send_item(bsfn_pkg::OP_SET, 10'd0);
    send_item(bsfn_pkg::OP_FIND, 10'd0);

    // Random phases, one capacity each
    for (int p = 0; p < 8; p++) begin
      write_capacity(phase_caps[p]);
      eff = (phase_caps[p] < MAP_BITS) ? phase_caps[p] : MAP_BITS;
      for (int n = 0; n < RANDOM_PER_PHASE; n++) begin
        sender_calm = (p % 2 == 1) && (n < 40);
        r = $urandom_range(0, 99);
        if (r < 30) op = bsfn_pkg::OP_SET;
        else if (r < 45) op = bsfn_pkg::OP_CLEAR;
        else if (r < 60) op = bsfn_pkg::OP_TEST;
        else if (r < 85) op = bsfn_pkg::OP_FIND;
        else if (r < 91) op = bsfn_pkg::OP_RESTART;
        else if (r < 93) op = bsfn_pkg::OP_CLEAR_ALL;
        else op = $urandom_range(0, 1) ? OP_SPARE_LO : OP_SPARE_HI;
        if (eff > 0 && $urandom_range(0, 9) < 8) idx = 10'($urandom_range(0, eff - 1));
        else idx = 10'($urandom_range(0, 1023));
        send_item(op, idx);
      end
    end
    sender_calm = 1'b0;

    // Wait out the last results, then let the bench idle before the verdict
    drain();
    repeat (30) @(negedge clk);
    if (sb.mismatches == 0 && sb.expected_results.size() == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

  initial begin : watchdog
    #10_000_000;
    $display("*** FAILED ***");
    $finish;
  end

endmodule
